// ===== design/afc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg - shared types and functions for the file-name ID block
// CRC-32 byte step, case folding, and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
  localparam logic [7:0]  CHAR_LC_A    = 8'h61;
  localparam logic [7:0]  CHAR_LC_Z    = 8'h7A;
  localparam logic [7:0]  CASE_OFFSET  = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAD  = 3'b010,
    S_DONE = 3'b100
  } afc_state_t;

  typedef struct packed {
    logic take;   // apply the accepted input beat
    logic pad;    // feed one padding byte into the CRC
    logic emit;   // load the ID into the output register and clear
  } afc_cmd_t;

  typedef struct packed {
    logic in_last;   // current input beat ends the name
    logic need_pad;  // name ending with this beat needs padding
    logic pad_last;  // this padding byte is the final one
    logic out_free;  // output register can take a new ID
  } afc_sts_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Fold ASCII lower case to upper case; everything else passes.
  function automatic logic [7:0] fold_upper(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
      r = ch - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== design/afc_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_char_if - character input channel
// One file-name character per beat, with empty and end-of-name flags.
// ----------------------------------------------------------------------------
interface afc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       no_char;
  logic       last_char;

  modport source (output valid, output name_char, output no_char, output last_char,
                  input ready);
  modport sink   (input valid, input name_char, input no_char, input last_char,
                  output ready);
endinterface

// ===== design/afc_id_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_id_if - ID result channel
// One 32-bit file ID per beat.
// ----------------------------------------------------------------------------
interface afc_id_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_id;

  modport source (output valid, output file_id, input ready);
  modport sink   (input valid, input file_id, output ready);
endinterface

// ===== design/afc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_datapath - CRC register, group tracking, padding and output register
// Executes take/pad/emit commands from the controller.
// ----------------------------------------------------------------------------
module afc_datapath
  import afc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  afc_cmd_t    cmd,
  output afc_sts_t    sts,
  input  logic [7:0]  in_name_char,
  input  logic        in_no_char,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_file_id
);

  logic [31:0] crc_r, crc_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        seen_r, seen_nxt;
  logic [1:0]  pad_rem_r, pad_rem_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] file_id_r, file_id_nxt;

  logic [7:0]  ch_up;
  logic [1:0]  len_after;
  logic        need_pad;
  logic [7:0]  pad_byte;

  assign ch_up     = fold_upper(in_name_char);
  assign len_after = in_no_char ? len_r : len_r + 2'd1;
  assign need_pad  = (seen_r || !in_no_char) && (len_after != 2'd0);
  assign pad_byte  = pad_first_r ? {6'd0, len_r} : first_r;

  assign sts.in_last  = in_last_char;
  assign sts.need_pad = need_pad;
  assign sts.pad_last = (pad_rem_r == 2'd1);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    crc_nxt       = crc_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    seen_nxt      = seen_r;
    pad_rem_nxt   = pad_rem_r;
    pad_first_nxt = pad_first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    file_id_nxt   = file_id_r;

    if (cmd.take) begin
      if (!in_no_char) begin
        if (len_r == 2'd0) begin
          first_nxt = ch_up;
        end
        crc_nxt  = crc_byte(crc_r, ch_up);
        len_nxt  = len_after;
        seen_nxt = 1'b1;
      end
      if (in_last_char) begin
        // pad with the remainder byte, then repeats of the group's first char
        pad_rem_nxt   = need_pad ? 2'(3'd4 - {1'b0, len_after}) : 2'd0;
        pad_first_nxt = 1'b1;
      end
    end

    if (cmd.pad) begin
      crc_nxt       = crc_byte(crc_r, pad_byte);
      pad_first_nxt = 1'b0;
      pad_rem_nxt   = pad_rem_r - 2'd1;
    end

    if (cmd.emit) begin
      file_id_nxt   = seen_r ? ~crc_r : 32'd0;
      out_valid_nxt = 1'b1;
      crc_nxt       = CRC_ALL_ONES;
      len_nxt       = 2'd0;
      first_nxt     = 8'd0;
      seen_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_ALL_ONES;
      len_r       <= 2'd0;
      first_r     <= 8'd0;
      seen_r      <= 1'b0;
      pad_rem_r   <= 2'd0;
      pad_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      seen_r      <= seen_nxt;
      pad_rem_r   <= pad_rem_nxt;
      pad_first_r <= pad_first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    file_id_r <= file_id_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_file_id = file_id_r;

  a_pad_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pad |-> pad_rem_r != 2'd0)
    else $error("padding step with no padding bytes left");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("ID emitted over an unaccepted result");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && !seen_r && crc_r == CRC_ALL_ONES)
    else $error("emit did not load the result and clear the name state");

endmodule

// ===== design/afc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_ctrl - sequencing for the file-name ID block
// Takes characters, steps the end padding, then hands the ID to the output.
// ----------------------------------------------------------------------------
module afc_ctrl
  import afc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  afc_sts_t sts,
  output afc_cmd_t cmd
);

  afc_state_t state_r, state_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = take;
        if (take && sts.in_last) begin
          state_nxt = sts.need_pad ? S_PAD : S_DONE;
        end
      end
      S_PAD: begin
        cmd.pad = 1'b1;
        if (sts.pad_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/archive_filename_crc_id.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_filename_crc_id - 32-bit archive ID from a streamed file name
// Usage:
//   in_char carries one name character per beat (name_char), with no_char
//   for a beat without a character and last_char on the final beat. Letters
//   a-z are folded to upper case and run through a reflected CRC-32.
//   out_id carries one file_id per name; an empty name gives zero.
// Sequence:
//   Beats that do not end the name are taken back to back. The ending
//   beat is followed by 4 - (length mod 4) padding bytes when the length
//   is not a multiple of four (none otherwise), then a step that loads
//   the output register. in_char.ready stays low until the load.
// Stall:
//   The ID sits in an output register until taken. Characters of the next
//   name are still accepted meanwhile; its ending beat waits in the load
//   step until the register frees.
// Reset:
//   Synchronous active-low rst_n clears the CRC and name state and drops
//   out_id.valid.
// ----------------------------------------------------------------------------
module archive_filename_crc_id
  import afc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  afc_char_if.sink in_char,
  afc_id_if.source out_id
);

  afc_cmd_t cmd;
  afc_sts_t sts;

  afc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_char.valid),
    .in_ready (in_char.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afc_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_name_char (in_char.name_char),
    .in_no_char   (in_char.no_char),
    .in_last_char (in_char.last_char),
    .out_valid    (out_id.valid),
    .out_ready    (out_id.ready),
    .out_file_id  (out_id.file_id)
  );

endmodule

// ===== tb/file_id_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_id_checker - file-name ID scoreboard
// Watches the character and ID channels. For every accepted character beat,
// it folds the case, runs its own reflected CRC-32 and pads a short final
// group. It queues the expected ID of each name and compares every ID beat
// against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module file_id_checker (
  input  logic clk,
  input  logic rst_n,
  afc_char_if  chars,
  afc_id_if    ids,
  output int   fail_count,
  output int   pending_ids,
  output int   ids_checked
);

  localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_SEED       = 32'hFFFFFFFF;
  localparam logic [7:0]  LOWER_A        = 8'h61;
  localparam logic [7:0]  LOWER_Z        = 8'h7A;
  localparam logic [7:0]  UPPER_SHIFT    = 8'h20;

  logic [31:0] crc_run;
  logic [1:0]  len_phase;
  logic [7:0]  group_lead;
  logic        got_char;
  logic [31:0] ids_due[$];
  logic [31:0] want;

  // Shift one byte in LSB first; feedback is the outgoing bit xor data bit.
  function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]};
      if (fb) begin
        c = c ^ REFLECTED_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= LOWER_A && b <= LOWER_Z) ? b - UPPER_SHIFT : b;
  endfunction

  // Pad a partial group with its length, then repeat its lead character.
  function automatic logic [31:0] closing_id();
    logic [31:0] c;
    if (!got_char) begin
      return 32'h0;
    end
    c = crc_run;
    if (len_phase != 2'd0) begin
      c = crc32_feed(c, {6'b0, len_phase});
      for (int i = len_phase; i < 3; i++) begin
        c = crc32_feed(c, group_lead);
      end
    end
    return ~c;
  endfunction

  task automatic clear_name();
    crc_run    = CRC_SEED;
    len_phase  = 2'd0;
    group_lead = 8'h00;
    got_char   = 1'b0;
  endtask

  task automatic take_beat(input logic [7:0] ch, input logic blank, input logic ends);
    logic [7:0] folded;
    if (!blank) begin
      folded = fold_case(ch);
      if (len_phase == 2'd0) begin
        group_lead = folded;
      end
      crc_run   = crc32_feed(crc_run, folded);
      len_phase = len_phase + 2'd1;
      got_char  = 1'b1;
    end
    if (ends) begin
      // append at the tail, oldest stays at the front
      ids_due = {ids_due, closing_id()};
      clear_name();
    end
  endtask

  // Sample mid-cycle: a beat seen here is accepted at the next rising edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_name();
      ids_due.delete();
    end else begin
      // Retire the outgoing ID before queueing a new one.
      if (ids.valid && ids.ready) begin
        if (ids_due.size() == 0) begin
          fail_count++;
          $display("%0t: file_id %h with no ID expected", $time, ids.file_id);
        end else begin
          want = ids_due.pop_front();
          ids_checked++;
          if (ids.file_id !== want) begin
            fail_count++;
            $display("%0t: file_id expected %h actual %h", $time, want, ids.file_id);
          end
        end
      end
      if (chars.valid && chars.ready) begin
        take_beat(chars.name_char, chars.no_char, chars.last_char);
      end
    end
    pending_ids = ids_due.size();
  end

endmodule

// ===== tb/archive_filename_crc_id_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_filename_crc_id_tb - file-name ID block testbench
// Streams directed and random file names into the block, with random gaps
// and back-pressure, one long receiver hold-off and one full drain. It
// leaves all checking to file_id_checker and reports the verdict.
// ----------------------------------------------------------------------------
module archive_filename_crc_id_tb;

  localparam int NAME_BEATS   = 1550;
  localparam int HOLD_AT      = 500;
  localparam int DRAIN_AT     = 1000;
  localparam int QUIET_AT     = NAME_BEATS - 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 10;
  localparam int LIMIT_CYCLES = 200000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_ids;
  int   ids_checked;
  int   beats_sent;
  int   cycle_count;
  int   names_sent;
  bit   idle_on;
  bit   hold_req;
  bit   hold_asked;
  bit   drained_once;

  afc_char_if char_ch ();
  afc_id_if   id_ch ();

  archive_filename_crc_id dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_char (char_ch),
    .out_id  (id_ch)
  );

  file_id_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars       (char_ch),
    .ids         (id_ch),
    .fail_count  (fail_count),
    .pending_ids (pending_ids),
    .ids_checked (ids_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(input logic [7:0] ch, input logic blank, input logic ends);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.name_char <= ch;
    char_ch.no_char   <= blank;
    char_ch.last_char <= ends;
    @(negedge clk);
    while (!char_ch.ready) @(negedge clk);
    @(posedge clk);
    if (!blank || ends) begin
      beats_sent++;
    end
  endtask

  function automatic logic [7:0] rand_name_byte();
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom_range(8'h40, 8'h5F));
    endcase
  endfunction

  // Mostly short names; a few long ones; some empty or closed by a blank beat.
  task automatic send_random_name();
    int  kind;
    int  len;
    bit  blank_end;
    kind      = $urandom_range(0, 19);
    blank_end = (kind >= 1 && kind <= 3);
    names_sent++;
    if (kind == 0) begin
      send_beat(rand_name_byte(), 1'b1, 1'b1);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_beat(rand_name_byte(), 1'b1, 1'b0);
        end
        send_beat(rand_name_byte(), 1'b0, (i == len - 1) && !blank_end);
      end
      if (blank_end) begin
        send_beat(rand_name_byte(), 1'b1, 1'b1);
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    id_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        id_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        id_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        id_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    char_ch.valid     <= 1'b0;
    char_ch.name_char <= 8'h00;
    char_ch.no_char   <= 1'b0;
    char_ch.last_char <= 1'b0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty name
    send_beat(8'h00, 1'b1, 1'b1);
    // One, two and three characters: every pad length
    send_beat(8'h61, 1'b0, 1'b1);
    send_beat(8'h7A, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h60, 1'b0, 1'b0);
    send_beat(8'h7B, 1'b0, 1'b1);
    // Full group with a blank beat inside, closed by a blank beat
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h71, 1'b0, 1'b0);
    send_beat(8'h41, 1'b0, 1'b0);
    send_beat(8'hAA, 1'b1, 1'b1);
    // Partial group closed by a blank beat, then an empty name with junk
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h3F, 1'b1, 1'b1);
    send_beat(8'hAA, 1'b1, 1'b1);

    while (beats_sent < NAME_BEATS) begin
      if (!hold_asked && beats_sent >= HOLD_AT) begin
        hold_asked = 1'b1;
        hold_req   = 1'b1;
      end
      if (!drained_once && beats_sent >= DRAIN_AT) begin
        drained_once = 1'b1;
        char_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_ids != 0);
      end
      if (beats_sent >= QUIET_AT) begin
        idle_on = 1'b0;
      end
      send_random_name();
    end
    char_ch.valid <= 1'b0;

    while (pending_ids != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d beats over %0d random names plus directed ones; %0d IDs compared.",
             beats_sent, names_sent, ids_checked);
    $display("Run had empty names, blank beats, all pad lengths, a long hold-off and a drain.");
    if (pending_ids != 0) begin
      $display("%0t: %0d expected IDs never arrived", $time, pending_ids);
    end
    if (fail_count == 0 && pending_ids == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
